FILE: hdl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Types and constants for the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

    // Input beat: one 8-bit RGB pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_pixel;

    // Output beat: hue in 1/64 degree, saturation and value.
    typedef struct packed {
        logic [14:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  value;
    } t_hsv_pixel;

    // Dominant channel, red winning ties, then green.
    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } t_sector;

    // Quotient widths of the two dividers.
    localparam int unsigned HUE_QBITS = 12;   // 3840*mag/delta <= 3840
    localparam int unsigned SAT_QBITS = 8;    // 255*delta/max  <= 255

    localparam logic [14:0] HUE_FULL   = 15'd23040;
    localparam logic [14:0] GREEN_BASE = 15'd7680;
    localparam logic [14:0] BLUE_BASE  = 15'd15360;

endpackage : rgbhsv_pkg

`default_nettype wire

FILE: hdl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pipelined RGB to HSV pixel converter with restoring dividers.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per clock and returns one HSV pixel per clock, in order,
// while the output is not stalled. A beat passes through 15 register stages;
// their number is set by the hue divider, which resolves one quotient bit per
// pipeline stage over 12 stages; the saturation divider runs alongside it in
// the first 8 of those stages. Stage one finds max, min and the dominant
// channel, stage two forms both dividends, and the last stage adds the sector
// base and wraps hue into 0..23039. Each stage holds its beat when the stage
// after it is full and stalled, so bubbles are squeezed out and a stall at the
// output backs up into o_stall only once the pipeline is full.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire rgbhsv_pkg::t_rgb_pixel  i_pixel,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output rgbhsv_pkg::t_hsv_pixel       o_pixel
);

    import rgbhsv_pkg::*;

    localparam int unsigned NDIV = HUE_QBITS;

    // ---------------- stage 1: max, min, dominant channel ----------------
    logic       r_s1_v;
    logic [7:0] r_s1_mx, r_s1_mn, r_s1_hi, r_s1_lo;
    t_sector    r_s1_sect;

    logic [7:0] n_mx, n_mn, n_hi, n_lo;
    t_sector    n_sect;

    logic              en_s1;
    logic [NDIV:0]     en_d;
    logic              en_out;

    always_comb begin
        n_mx = i_pixel.red;
        n_mn = i_pixel.red;
        if (i_pixel.green > n_mx) n_mx = i_pixel.green;
        if (i_pixel.blue  > n_mx) n_mx = i_pixel.blue;
        if (i_pixel.green < n_mn) n_mn = i_pixel.green;
        if (i_pixel.blue  < n_mn) n_mn = i_pixel.blue;
        if (n_mx == i_pixel.red) begin
            n_sect = SECT_RED;
            n_hi   = i_pixel.green;
            n_lo   = i_pixel.blue;
        end else if (n_mx == i_pixel.green) begin
            n_sect = SECT_GREEN;
            n_hi   = i_pixel.blue;
            n_lo   = i_pixel.red;
        end else begin
            n_sect = SECT_BLUE;
            n_hi   = i_pixel.red;
            n_lo   = i_pixel.green;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en_s1) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_mx   <= n_mx;
            r_s1_mn   <= n_mn;
            r_s1_hi   <= n_hi;
            r_s1_lo   <= n_lo;
            r_s1_sect <= n_sect;
        end
    end

    // ---------------- divider pipeline, entry 0 is the dividend stage ----------------
    logic                 r_dv    [0:NDIV];
    logic [7:0]           r_hrem  [0:NDIV];
    logic [HUE_QBITS-1:0] r_hlow  [0:NDIV];
    logic [HUE_QBITS-1:0] r_hquo  [0:NDIV];
    logic [7:0]           r_hdiv  [0:NDIV];
    logic [7:0]           r_srem  [0:NDIV];
    logic [SAT_QBITS-1:0] r_slow  [0:NDIV];
    logic [SAT_QBITS-1:0] r_squo  [0:NDIV];
    logic [7:0]           r_val   [0:NDIV];
    logic                 r_neg   [0:NDIV];
    logic                 r_zero  [0:NDIV];
    t_sector              r_sect  [0:NDIV];

    // Dividends: 3840*mag = (15*mag) << 8, 255*delta = (delta << 8) - delta.
    logic [7:0]  n_delta, n_mag;
    logic        n_neg;
    logic [11:0] n_mag15;
    logic [15:0] n_snum;

    always_comb begin
        n_delta = r_s1_mx - r_s1_mn;
        n_neg   = (r_s1_hi < r_s1_lo);
        n_mag   = n_neg ? (r_s1_lo - r_s1_hi) : (r_s1_hi - r_s1_lo);
        n_mag15 = {n_mag, 4'b0000} - {4'b0000, n_mag};
        n_snum  = {n_delta, 8'h00} - {8'h00, n_delta};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en_d[0]) begin
            r_dv[0] <= r_s1_v;
        end
    end

    // Upper dividend bits are already below the divisor since mag <= delta <= max.
    always_ff @(posedge i_clk) begin
        if (en_d[0]) begin
            r_hrem[0] <= n_mag15[11:4];
            r_hlow[0] <= {n_mag15[3:0], 8'h00};
            r_hquo[0] <= '0;
            r_hdiv[0] <= n_delta;
            r_srem[0] <= n_snum[15:8];
            r_slow[0] <= n_snum[7:0];
            r_squo[0] <= '0;
            r_val[0]  <= r_s1_mx;
            r_neg[0]  <= n_neg;
            r_zero[0] <= (n_delta == 8'h00);
            r_sect[0] <= r_s1_sect;
        end
    end

    genvar j;
    generate
        for (j = 1; j <= NDIV; j++) begin : g_div
            logic [8:0] n_ht, n_st;
            logic       n_hge, n_sge;

            always_comb begin
                n_ht  = {r_hrem[j-1], r_hlow[j-1][HUE_QBITS-1]};
                n_hge = (n_ht >= {1'b0, r_hdiv[j-1]});
                n_st  = {r_srem[j-1], r_slow[j-1][SAT_QBITS-1]};
                n_sge = (n_st >= {1'b0, r_val[j-1]});
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[j] <= 1'b0;
                end else if (en_d[j]) begin
                    r_dv[j] <= r_dv[j-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en_d[j]) begin
                    r_hrem[j] <= n_hge ? 8'(n_ht - {1'b0, r_hdiv[j-1]}) : n_ht[7:0];
                    r_hlow[j] <= {r_hlow[j-1][HUE_QBITS-2:0], 1'b0};
                    r_hquo[j] <= {r_hquo[j-1][HUE_QBITS-2:0], n_hge};
                    r_hdiv[j] <= r_hdiv[j-1];
                    r_val[j]  <= r_val[j-1];
                    r_neg[j]  <= r_neg[j-1];
                    r_zero[j] <= r_zero[j-1];
                    r_sect[j] <= r_sect[j-1];
                    if (j <= SAT_QBITS) begin
                        r_srem[j] <= n_sge ? 8'(n_st - {1'b0, r_val[j-1]}) : n_st[7:0];
                        r_slow[j] <= {r_slow[j-1][SAT_QBITS-2:0], 1'b0};
                        r_squo[j] <= {r_squo[j-1][SAT_QBITS-2:0], n_sge};
                    end else begin
                        // saturation quotient is done: carry it along
                        r_srem[j] <= r_srem[j-1];
                        r_slow[j] <= r_slow[j-1];
                        r_squo[j] <= r_squo[j-1];
                    end
                end
            end
        end

        for (j = 0; j < NDIV; j++) begin : g_en
            assign en_d[j] = !r_dv[j] || en_d[j+1];
        end
    endgenerate

    assign en_d[NDIV] = !r_dv[NDIV] || en_out;
    assign en_s1      = !r_s1_v || en_d[0];
    assign en_out     = !o_valid || !i_stall;
    assign o_stall    = !en_s1;

    // ---------------- output stage: sector base and wrap ----------------
    logic [14:0] n_off, n_hue;
    logic [7:0]  n_sat;

    always_comb begin
        n_off = {3'b000, r_hquo[NDIV]};
        unique case (r_sect[NDIV])
            SECT_RED: begin
                if (!r_neg[NDIV])
                    n_hue = n_off;
                else if (n_off == 15'd0)
                    n_hue = '0;
                else
                    n_hue = HUE_FULL - n_off;
            end
            SECT_GREEN: n_hue = r_neg[NDIV] ? (GREEN_BASE - n_off) : (GREEN_BASE + n_off);
            SECT_BLUE:  n_hue = r_neg[NDIV] ? (BLUE_BASE - n_off) : (BLUE_BASE + n_off);
            default:    n_hue = '0;
        endcase
        // grey or black: drop both quotients
        if (r_zero[NDIV]) n_hue = '0;
        n_sat = r_zero[NDIV] ? 8'h00 : r_squo[NDIV];
    end

    logic       r_o_valid;
    t_hsv_pixel r_o_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_out) begin
            r_o_valid <= r_dv[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_o_pixel.hue        <= n_hue;
            r_o_pixel.saturation <= n_sat;
            r_o_pixel.value      <= r_val[NDIV];
        end
    end

    assign o_valid = r_o_valid;
    assign o_pixel = r_o_pixel;

endmodule : rgb_to_hsv_converter

`default_nettype wire
